// ----- src/ltic_pkg.sv -----
package ltic_pkg;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_OPEN_LOOP = 2'd1,
		OP_POSITION  = 2'd2,
		OP_MACRO     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_STAGE_THRESHOLD  = 3'd0,
		CFG_TRAY_LOW_TARGET  = 3'd1,
		CFG_TRAY_HIGH_TARGET = 3'd2,
		CFG_LIFT_MARGIN      = 3'd3,
		CFG_TRAY_MARGIN      = 3'd4
	} cfg_index_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic        [11:0] STAGE_THRESHOLD_RST  = 12'd2000;
	localparam logic signed [15:0] TRAY_LOW_TARGET_RST  = 16'sd0;
	localparam logic signed [15:0] TRAY_HIGH_TARGET_RST = 16'sd1000;
	localparam logic signed [12:0] LIFT_MARGIN_RST      = 13'sd100;
	localparam logic        [15:0] TRAY_MARGIN_RST      = 16'd100;

	localparam logic signed [13:0] ARRIVE_BAND       = 14'sd50;
	localparam logic signed [13:0] LOW_CUTOFF_LIFT   = 14'sd250;
	localparam logic signed [13:0] LOW_CUTOFF_DEMAND = 14'sd300;
	localparam logic signed [14:0] NEG_OFFSET        = 15'sd75;
	localparam logic signed [8:0]  VEL_MAX           = 9'sd200;
	localparam logic signed [8:0]  VEL_MIN           = -9'sd200;

endpackage

// ----- src/lift_tray_interlock_controller.sv -----
// Lift and tray interlock controller. Takes one item per clock cycle when the
// result side is not stalled and gives one result item for every input item.
// Each accepted item passes through the input register, where the command or
// tick is decoded against the mode, demand and macro state, and then through
// the result register. Command items update the state and return a result
// with no drive and no tray setpoint. Configuration must be written through
// the plain write port while no item is in flight; the block does not enforce it.
module lift_tray_interlock_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ltic_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [ltic_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  ltic_pkg::opcode_t                     opcode,
	input  logic signed [12:0]                    demand_value,
	input  logic        [11:0]                    lift_position,
	input  logic signed [15:0]                    tray_position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  lift_drive_valid,
	output logic signed [8:0]                     lift_velocity,
	output logic                                  tray_cmd_valid,
	output logic signed [15:0]                    tray_setpoint,
	output logic                                  mode_out,
	output logic signed [13:0]                    position_error
);
	import ltic_pkg::*;

	logic        [11:0] stage_threshold_q;
	logic signed [15:0] tray_low_target_q;
	logic signed [15:0] tray_high_target_q;
	logic signed [12:0] lift_margin_q;
	logic        [15:0] tray_margin_q;

	logic               mode_q;
	logic signed [12:0] demand_q;
	logic               macro_q;

	logic               valid_s1;
	opcode_t            opcode_s1;
	logic signed [12:0] demand_value_s1;
	logic        [11:0] lift_s1;
	logic signed [15:0] tray_s1;

	logic               valid_s2;
	logic               dvalid_s2;
	logic signed [8:0]  vel_s2;
	logic               tvalid_s2;
	logic signed [15:0] tsp_s2;
	logic               mode_s2;
	logic signed [13:0] perr_s2;

	logic               adv_s2;
	logic               adv_s1;

	logic               n_mode;
	logic signed [12:0] n_demand;
	logic               n_macro;
	logic               dvalid;
	logic signed [8:0]  vel;
	logic               tvalid;
	logic signed [15:0] tsp;
	logic signed [13:0] perr;

	logic signed [13:0] lift_ext;
	logic signed [13:0] demand_ext;
	logic signed [13:0] err;
	logic signed [14:0] err_off;
	logic               arrive;
	logic signed [8:0]  loop_vel;
	logic signed [8:0]  open_vel;
	logic signed [15:0] target;
	logic signed [13:0] release_diff;
	logic signed [16:0] tray_err;
	logic signed [17:0] tray_margin_ext;
	logic               tray_near;

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign adv_s1   = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_threshold_q  <= STAGE_THRESHOLD_RST;
			tray_low_target_q  <= TRAY_LOW_TARGET_RST;
			tray_high_target_q <= TRAY_HIGH_TARGET_RST;
			lift_margin_q      <= LIFT_MARGIN_RST;
			tray_margin_q      <= TRAY_MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STAGE_THRESHOLD:  stage_threshold_q  <= cfg_data[11:0];
				CFG_TRAY_LOW_TARGET:  tray_low_target_q  <= cfg_data;
				CFG_TRAY_HIGH_TARGET: tray_high_target_q <= cfg_data;
				CFG_LIFT_MARGIN:      lift_margin_q      <= cfg_data[12:0];
				CFG_TRAY_MARGIN:      tray_margin_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1       <= opcode;
			demand_value_s1 <= demand_value;
			lift_s1         <= lift_position;
			tray_s1         <= tray_position;
		end
	end

	assign lift_ext   = {2'b00, lift_s1};
	assign demand_ext = {demand_q[12], demand_q};
	assign err        = demand_ext - lift_ext;
	assign err_off    = demand_q[12] ? ({err[13], err} + NEG_OFFSET) : {err[13], err};
	assign arrive     = (err < ARRIVE_BAND && err > -ARRIVE_BAND) ||
	                    (lift_ext < LOW_CUTOFF_LIFT && demand_ext < LOW_CUTOFF_DEMAND);
	assign loop_vel   = err_off[14] ? VEL_MAX : VEL_MIN;

	always_comb begin
		if (demand_q > 13'sd200) begin
			open_vel = VEL_MAX;
		end else if (demand_q < -13'sd200) begin
			open_vel = VEL_MIN;
		end else begin
			open_vel = demand_q[8:0];
		end
	end

	always_comb begin
		if (demand_q[12]) begin
			target = tray_s1;
		end else if (demand_ext > $signed({2'b00, stage_threshold_q})) begin
			target = tray_high_target_q;
		end else begin
			target = tray_low_target_q;
		end
	end

	assign release_diff    = arrive ? lift_ext : (lift_ext - demand_ext);
	assign tray_err        = {tray_s1[15], tray_s1} - {target[15], target};
	assign tray_margin_ext = {2'b00, tray_margin_q};
	assign tray_near       = ($signed({tray_err[16], tray_err}) < tray_margin_ext) &&
	                         ($signed({tray_err[16], tray_err}) > -tray_margin_ext);

	always_comb begin
		n_mode   = mode_q;
		n_demand = demand_q;
		n_macro  = macro_q;
		dvalid   = 1'b0;
		vel      = '0;
		tvalid   = 1'b0;
		tsp      = '0;
		perr     = '0;
		unique case (opcode_s1)
			OP_OPEN_LOOP: begin
				n_mode   = 1'b0;
				n_demand = demand_value_s1;
			end
			OP_POSITION: begin
				n_mode   = 1'b1;
				n_demand = demand_value_s1;
				n_macro  = 1'b0;
			end
			OP_MACRO: begin
				n_mode   = 1'b1;
				n_demand = demand_value_s1;
				n_macro  = 1'b1;
			end
			OP_TICK: begin
				perr = err;
				if (!mode_q) begin
					dvalid = 1'b1;
					vel    = open_vel;
				end else begin
					// The loop runs in macro mode, at the low target, or once the tray is near its target.
					if (macro_q || target == tray_low_target_q || tray_near) begin
						if (arrive) begin
							n_mode   = 1'b0;
							n_demand = '0;
						end else begin
							dvalid = 1'b1;
							vel    = loop_vel;
						end
					end
					if (!macro_q) begin
						if (target != tray_low_target_q ||
						    release_diff < $signed({lift_margin_q[12], lift_margin_q})) begin
							tvalid = 1'b1;
							tsp    = target;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			demand_q <= '0;
			macro_q  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				mode_q   <= n_mode;
				demand_q <= n_demand;
				macro_q  <= n_macro;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dvalid_s2 <= dvalid;
			vel_s2    <= vel;
			tvalid_s2 <= tvalid;
			tsp_s2    <= tsp;
			mode_s2   <= n_mode;
			perr_s2   <= perr;
		end
	end

	assign out_valid        = valid_s2;
	assign lift_drive_valid = dvalid_s2;
	assign lift_velocity    = vel_s2;
	assign tray_cmd_valid   = tvalid_s2;
	assign tray_setpoint    = tsp_s2;
	assign mode_out         = mode_s2;
	assign position_error   = perr_s2;

endmodule
